>>> design/owb_pkg.sv
// One-wire bus master package: beat types, configuration register indexes
// and reset values, command and phase codes. Depends on nothing.
package owb_pkg;

	localparam int NUM_REGS = 8;
	localparam int REG_BITS = 16;

	// configuration register indexes
	localparam logic [2:0] REG_RESET_LOW      = 3'd0;
	localparam logic [2:0] REG_PRESENCE_WAIT  = 3'd1;
	localparam logic [2:0] REG_RESET_TAIL     = 3'd2;
	localparam logic [2:0] REG_WRITE_ONE_LOW  = 3'd3;
	localparam logic [2:0] REG_WRITE_ONE_TAIL = 3'd4;
	localparam logic [2:0] REG_WRITE_ZERO_LOW = 3'd5;
	localparam logic [2:0] REG_READ_LOW       = 3'd6;
	localparam logic [2:0] REG_READ_TAIL      = 3'd7;

	// reset values of the configuration registers
	localparam logic [REG_BITS-1:0] RESET_LOW_DEF      = 16'd500;
	localparam logic [REG_BITS-1:0] PRESENCE_WAIT_DEF  = 16'd65;
	localparam logic [REG_BITS-1:0] RESET_TAIL_DEF     = 16'd400;
	localparam logic [REG_BITS-1:0] WRITE_ONE_LOW_DEF  = 16'd1;
	localparam logic [REG_BITS-1:0] WRITE_ONE_TAIL_DEF = 16'd60;
	localparam logic [REG_BITS-1:0] WRITE_ZERO_LOW_DEF = 16'd60;
	localparam logic [REG_BITS-1:0] READ_LOW_DEF       = 16'd2;
	localparam logic [REG_BITS-1:0] READ_TAIL_DEF      = 16'd60;

	// command codes
	localparam logic [1:0] KIND_NONE  = 2'd0;
	localparam logic [1:0] KIND_RESET = 2'd1;
	localparam logic [1:0] KIND_WRITE = 2'd2;
	localparam logic [1:0] KIND_READ  = 2'd3;

	// sequencer phases
	localparam logic [2:0] PH_IDLE       = 3'd0;
	localparam logic [2:0] PH_RST_LOW    = 3'd1;
	localparam logic [2:0] PH_RST_WAIT   = 3'd2;
	localparam logic [2:0] PH_RST_SAMPLE = 3'd3;
	localparam logic [2:0] PH_RST_TAIL   = 3'd4;
	localparam logic [2:0] PH_BIT_LOW    = 3'd5;
	localparam logic [2:0] PH_BIT_SAMPLE = 3'd6;
	localparam logic [2:0] PH_BIT_TAIL   = 3'd7;

	typedef logic [NUM_REGS-1:0][REG_BITS-1:0] cfg_regs_t;

	typedef struct packed {
		logic [1:0] kind;
		logic [7:0] write_data;
		logic       bus_level;
	} in_item_t;

	typedef struct packed {
		logic       drive_low;
		logic       busy_res;
		logic       done_res;
		logic       presence;
		logic [7:0] read_data;
	} out_item_t;

endpackage

>>> design/owb_engine.sv
// Bus sequencer of the one-wire master: phase state, timer, shift registers
// and the per-tick result. Depends on owb_pkg.
module owb_engine
	import owb_pkg::*;
#(
	parameter int TIMER_BITS = 16
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      step,
	input  in_item_t  item,
	input  cfg_regs_t regs,
	output out_item_t result,
	output logic      busy
);

	logic [2:0]            phase_q;
	logic [TIMER_BITS-1:0] timer_q;
	logic [2:0]            bit_count_q;
	logic [7:0]            send_q;
	logic [7:0]            recv_q;
	logic                  presence_q;
	logic                  reading_q;
	logic [7:0]            held_read_q;

	logic [2:0]            ph_n;
	logic [TIMER_BITS-1:0] tmr_n;
	logic [2:0]            bc_n;
	logic [7:0]            ss_n;
	logic [7:0]            rs_n;
	logic                  pf_n;
	logic                  rd_n;
	logic [7:0]            hr_n;
	logic                  drive;
	logic                  done;
	logic                  next_bit;
	logic                  tail_req;
	logic [REG_BITS-1:0]   tail_len;
	logic                  expired;

	// Length cut to the timer width, zero-extended when the timer is wider.
	function automatic logic [TIMER_BITS-1:0] cut(input logic [REG_BITS-1:0] v);
		logic [TIMER_BITS+REG_BITS-1:0] wide;
		wide = {{TIMER_BITS{1'b0}}, v};
		return wide[TIMER_BITS-1:0];
	endfunction

	// A low or wait phase of length zero still lasts one tick.
	function automatic logic [TIMER_BITS-1:0] len_min1(input logic [REG_BITS-1:0] v);
		logic [TIMER_BITS-1:0] t;
		t = cut(v);
		return (t == '0) ? TIMER_BITS'(1) : t;
	endfunction

	always_comb begin
		ph_n     = phase_q;
		tmr_n    = timer_q;
		bc_n     = bit_count_q;
		ss_n     = send_q;
		rs_n     = recv_q;
		pf_n     = presence_q;
		rd_n     = reading_q;
		hr_n     = held_read_q;
		drive    = 1'b0;
		done     = 1'b0;
		next_bit = 1'b0;
		tail_req = 1'b0;
		tail_len = '0;

		// command start, only from idle
		if (phase_q == PH_IDLE && item.kind != KIND_NONE) begin
			bc_n = '0;
			if (item.kind == KIND_RESET) begin
				ph_n  = PH_RST_LOW;
				tmr_n = len_min1(regs[REG_RESET_LOW]);
			end else begin
				rd_n  = (item.kind == KIND_READ);
				ss_n  = rd_n ? 8'd0 : item.write_data;
				rs_n  = '0;
				ph_n  = PH_BIT_LOW;
				if (rd_n)
					tmr_n = len_min1(regs[REG_READ_LOW]);
				else if (ss_n[0])
					tmr_n = len_min1(regs[REG_WRITE_ONE_LOW]);
				else
					tmr_n = len_min1(regs[REG_WRITE_ZERO_LOW]);
			end
		end

		expired = (tmr_n == TIMER_BITS'(1));

		case (ph_n)
			PH_IDLE: begin
			end
			PH_RST_LOW: begin
				drive = 1'b1;
				tmr_n = tmr_n - TIMER_BITS'(1);
				if (expired) begin
					ph_n  = PH_RST_WAIT;
					tmr_n = len_min1(regs[REG_PRESENCE_WAIT]);
				end
			end
			PH_RST_WAIT: begin
				tmr_n = tmr_n - TIMER_BITS'(1);
				if (expired)
					ph_n = PH_RST_SAMPLE;
			end
			PH_RST_SAMPLE: begin
				pf_n  = ~item.bus_level;
				tmr_n = cut(regs[REG_RESET_TAIL]);
				if (tmr_n == '0) begin
					ph_n = PH_IDLE;
					done = 1'b1;
				end else begin
					ph_n = PH_RST_TAIL;
				end
			end
			PH_RST_TAIL: begin
				tmr_n = tmr_n - TIMER_BITS'(1);
				if (expired) begin
					ph_n = PH_IDLE;
					done = 1'b1;
				end
			end
			PH_BIT_LOW: begin
				drive = 1'b1;
				tmr_n = tmr_n - TIMER_BITS'(1);
				if (expired) begin
					if (rd_n) begin
						ph_n = PH_BIT_SAMPLE;
					end else if (ss_n[0]) begin
						tail_req = 1'b1;
						tail_len = regs[REG_WRITE_ONE_TAIL];
					end else begin
						next_bit = 1'b1;
					end
				end
			end
			PH_BIT_SAMPLE: begin
				rs_n     = {item.bus_level, rs_n[7:1]};
				tail_req = 1'b1;
				tail_len = regs[REG_READ_TAIL];
			end
			default: begin
				tmr_n = tmr_n - TIMER_BITS'(1);
				if (expired)
					next_bit = 1'b1;
			end
		endcase

		// a zero tail is skipped straight to the next bit
		if (tail_req) begin
			if (cut(tail_len) == '0) begin
				next_bit = 1'b1;
			end else begin
				ph_n  = PH_BIT_TAIL;
				tmr_n = cut(tail_len);
			end
		end

		if (next_bit) begin
			if (bc_n == 3'd7) begin
				ph_n = PH_IDLE;
				bc_n = '0;
				if (rd_n)
					hr_n = rs_n;
				done = 1'b1;
			end else begin
				bc_n = bc_n + 3'd1;
				ss_n = {1'b0, ss_n[7:1]};
				ph_n = PH_BIT_LOW;
				if (rd_n)
					tmr_n = len_min1(regs[REG_READ_LOW]);
				else if (ss_n[0])
					tmr_n = len_min1(regs[REG_WRITE_ONE_LOW]);
				else
					tmr_n = len_min1(regs[REG_WRITE_ZERO_LOW]);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_IDLE;
			timer_q     <= '0;
			bit_count_q <= '0;
			send_q      <= '0;
			recv_q      <= '0;
			presence_q  <= 1'b0;
			reading_q   <= 1'b0;
			held_read_q <= '0;
		end else if (step) begin
			phase_q     <= ph_n;
			timer_q     <= tmr_n;
			bit_count_q <= bc_n;
			send_q      <= ss_n;
			recv_q      <= rs_n;
			presence_q  <= pf_n;
			reading_q   <= rd_n;
			held_read_q <= hr_n;
		end
	end

	// The busy flag of a tick covers the accepting tick as well.
	assign result.drive_low = drive;
	assign result.busy_res  = (phase_q != PH_IDLE) || (item.kind != KIND_NONE);
	assign result.done_res  = done;
	assign result.presence  = pf_n;
	assign result.read_data = hr_n;
	assign busy             = (phase_q != PH_IDLE);

endmodule

>>> design/one_wire_bus_master.sv
// Top level of the one-wire bus master: input register, configuration
// registers, sequencer instance and a two-entry result buffer.
// Depends on owb_pkg and owb_engine.

// One input beat is one microsecond tick of the bus; it carries the sampled
// line level and an optional command (reset, write byte, read byte), and
// each tick yields exactly one result beat with the drive level and status.
// The block takes one tick in every clock cycle while in_stall is low. A
// beat is first captured in an input register; once the buffer has a free
// entry the sequencer works out the tick in one pass of short logic and the
// result is written into a two-entry buffer that drives the output. The
// buffer lets a new tick be accepted while an earlier result still waits;
// only when both buffer entries are held and the input register is full
// does in_stall rise. Commands that arrive while a command is running are
// ignored. The eight 16-bit timing registers are written through the plain
// write port and must only be changed while the master is idle and all
// results have drained. TIMER_BITS sets the phase timer width; every timing
// value is cut to that many bits when it is loaded.
module one_wire_bus_master
	import owb_pkg::*;
#(
	parameter int TIMER_BITS = 16
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  in_item_t            in_data,
	output logic                out_valid,
	input  logic                out_stall,
	output out_item_t           out_data,
	input  logic                cfg_wr_en,
	input  logic [2:0]          cfg_index,
	input  logic [REG_BITS-1:0] cfg_data
);

	cfg_regs_t regs_q;

	// input register stage
	logic     valid_s1;
	in_item_t item_s1;

	// result buffer: two entries, circular
	out_item_t fifo_q [2];
	logic      rd_ptr_q;
	logic      wr_ptr_q;
	logic [1:0] count_q;

	logic      in_take;
	logic      out_take;
	logic      advance;
	logic      eng_busy;
	out_item_t result;

	// The stage moves on whenever the buffer has a free entry; this is a
	// registered condition so the output stall never reaches the input.
	assign advance  = valid_s1 && (count_q != 2'd2);
	assign in_stall = valid_s1 && !advance;
	assign in_take  = in_valid && !in_stall;
	assign out_take = out_valid && !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs_q[REG_RESET_LOW]      <= RESET_LOW_DEF;
			regs_q[REG_PRESENCE_WAIT]  <= PRESENCE_WAIT_DEF;
			regs_q[REG_RESET_TAIL]     <= RESET_TAIL_DEF;
			regs_q[REG_WRITE_ONE_LOW]  <= WRITE_ONE_LOW_DEF;
			regs_q[REG_WRITE_ONE_TAIL] <= WRITE_ONE_TAIL_DEF;
			regs_q[REG_WRITE_ZERO_LOW] <= WRITE_ZERO_LOW_DEF;
			regs_q[REG_READ_LOW]       <= READ_LOW_DEF;
			regs_q[REG_READ_TAIL]      <= READ_TAIL_DEF;
		end else if (cfg_wr_en) begin
			regs_q[cfg_index] <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_take) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_take)
			item_s1 <= in_data;
	end

	owb_engine #(
		.TIMER_BITS(TIMER_BITS)
	) u_engine (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (advance),
		.item   (item_s1),
		.regs   (regs_q),
		.result (result),
		.busy   (eng_busy)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_ptr_q <= 1'b0;
			wr_ptr_q <= 1'b0;
			count_q  <= '0;
		end else begin
			if (advance)
				wr_ptr_q <= ~wr_ptr_q;
			if (out_take)
				rd_ptr_q <= ~rd_ptr_q;
			if (advance && !out_take)
				count_q <= count_q + 2'd1;
			else if (!advance && out_take)
				count_q <= count_q - 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance)
			fifo_q[wr_ptr_q] <= result;
	end

	assign out_valid = (count_q != 2'd0);
	assign out_data  = fifo_q[rd_ptr_q];

	// The buffer never holds more than two results.
	assert property (@(posedge clk) disable iff (!arst_n) count_q <= 2'd2)
		else $error("result buffer overfilled");

	// A tick that completes a command or drives the line is a busy tick.
	assert property (@(posedge clk) disable iff (!arst_n)
		advance && (result.done_res || result.drive_low) |-> result.busy_res)
		else $error("done or drive outside a command");

	// A result pushed without a pop grows the buffer by exactly one.
	assert property (@(posedge clk) disable iff (!arst_n)
		advance && !out_take |=> count_q == $past(count_q) + 2'd1)
		else $error("result buffer count slipped");

	// The sequencer only leaves idle when a tick is processed.
	assert property (@(posedge clk) disable iff (!arst_n)
		!advance && !eng_busy |=> !eng_busy)
		else $error("sequencer started without a tick");

endmodule

>>> sim/testbench.sv
// Self-checking testbench for one_wire_bus_master: feeds microsecond ticks with commands,
// predicts every result beat and compares it field by field.
// Depends on owb_pkg and the one_wire_bus_master design files.
module testbench;
	import owb_pkg::*;

	localparam int CYCLE_LIMIT = 200_000;
	localparam int BUS_LOW     = 0;
	localparam int BUS_HIGH    = 1;
	localparam int BUS_RANDOM  = 2;

	logic                clk;
	logic                arst_n;
	logic                in_valid;
	logic                in_stall;
	in_item_t            in_data;
	logic                out_valid;
	logic                out_stall;
	out_item_t           out_data;
	logic                cfg_wr_en;
	logic [2:0]          cfg_index;
	logic [REG_BITS-1:0] cfg_data;

	// Ticks waiting to be sent, and the predicted result of every accepted tick.
	in_item_t  pending_ticks[$];
	out_item_t due_outputs[$];

	// Predicted master state and its copy of the timing registers.
	cfg_regs_t   timing;
	logic [2:0]  seq_phase  = PH_IDLE;
	logic [15:0] seq_timer  = '0;
	logic [2:0]  bit_index  = '0;
	logic [7:0]  tx_byte    = '0;
	logic [7:0]  rx_byte    = '0;
	logic        presence_q = 1'b0;
	logic        reading_q  = 1'b0;
	logic [7:0]  held_byte  = '0;

	logic in_taken  = 1'b0;
	logic out_taken = 1'b0;
	logic burst     = 1'b0;
	int   send_gap  = 0;
	int   hold_left = 0;

	int cycle_count      = 0;
	int mismatches       = 0;
	int ticks_seen       = 0;
	int ticks_queued     = 0;
	int commands_started = 0;
	int settings_run     = 0;

	one_wire_bus_master #(.TIMER_BITS(16)) dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// A length of zero still takes one tick in the low and wait phases.
	function automatic logic [15:0] at_least_one(logic [15:0] v);
		return (v == '0) ? 16'd1 : v;
	endfunction

	function automatic void load_bit_low();
		seq_phase = PH_BIT_LOW;
		if (reading_q) begin
			seq_timer = at_least_one(timing[REG_READ_LOW]);
		end else if (tx_byte[0]) begin
			seq_timer = at_least_one(timing[REG_WRITE_ONE_LOW]);
		end else begin
			seq_timer = at_least_one(timing[REG_WRITE_ZERO_LOW]);
		end
	endfunction

	// Moves on to the next bit slot; returns 1 when the byte is complete.
	function automatic logic advance_bit();
		if (bit_index == 3'd7) begin
			seq_phase = PH_IDLE;
			bit_index = '0;
			if (reading_q)
				held_byte = rx_byte;
			return 1'b1;
		end
		bit_index = bit_index + 1'b1;
		tx_byte   = tx_byte >> 1;
		load_bit_low();
		return 1'b0;
	endfunction

	// A tail of zero is skipped altogether.
	function automatic logic open_tail(logic [15:0] len);
		if (len == '0)
			return advance_bit();
		seq_phase = PH_BIT_TAIL;
		seq_timer = len;
		return 1'b0;
	endfunction

	// Works out the result beat of one tick and advances the predicted state.
	function automatic out_item_t step_master(in_item_t beat);
		out_item_t res;
		res = '0;
		if (seq_phase == PH_IDLE && beat.kind != KIND_NONE) begin
			commands_started++;
			bit_index = '0;
			if (beat.kind == KIND_RESET) begin
				seq_phase = PH_RST_LOW;
				seq_timer = at_least_one(timing[REG_RESET_LOW]);
			end else begin
				reading_q = (beat.kind == KIND_READ);
				tx_byte   = reading_q ? 8'h00 : beat.write_data;
				rx_byte   = '0;
				load_bit_low();
			end
		end
		if (seq_phase != PH_IDLE) begin
			res.busy_res = 1'b1;
			case (seq_phase)
			PH_RST_LOW: begin
				res.drive_low = 1'b1;
				seq_timer = seq_timer - 1'b1;
				if (seq_timer == '0) begin
					seq_phase = PH_RST_WAIT;
					seq_timer = at_least_one(timing[REG_PRESENCE_WAIT]);
				end
			end
			PH_RST_WAIT: begin
				seq_timer = seq_timer - 1'b1;
				if (seq_timer == '0)
					seq_phase = PH_RST_SAMPLE;
			end
			PH_RST_SAMPLE: begin
				presence_q = !beat.bus_level;
				seq_timer  = timing[REG_RESET_TAIL];
				if (seq_timer == '0) begin
					seq_phase    = PH_IDLE;
					res.done_res = 1'b1;
				end else begin
					seq_phase = PH_RST_TAIL;
				end
			end
			PH_RST_TAIL: begin
				seq_timer = seq_timer - 1'b1;
				if (seq_timer == '0) begin
					seq_phase    = PH_IDLE;
					res.done_res = 1'b1;
				end
			end
			PH_BIT_LOW: begin
				res.drive_low = 1'b1;
				seq_timer = seq_timer - 1'b1;
				if (seq_timer == '0) begin
					if (reading_q)
						seq_phase = PH_BIT_SAMPLE;
					else if (tx_byte[0])
						res.done_res = open_tail(timing[REG_WRITE_ONE_TAIL]);
					else
						res.done_res = advance_bit();
				end
			end
			PH_BIT_SAMPLE: begin
				rx_byte      = {beat.bus_level, rx_byte[7:1]};
				res.done_res = open_tail(timing[REG_READ_TAIL]);
			end
			default: begin
				seq_timer = seq_timer - 1'b1;
				if (seq_timer == '0)
					res.done_res = advance_bit();
			end
			endcase
		end
		res.presence  = presence_q;
		res.read_data = held_byte;
		return res;
	endfunction

	// Idle cycles before the next beat or between results; long runs go without any.
	function automatic int pick_wait();
		if ($urandom_range(0, 39) == 0)
			burst = !burst;
		if (burst)
			return 0;
		return $urandom_range(0, 18);
	endfunction

	function automatic logic bus_pick(int mode);
		case (mode)
		BUS_LOW:  return 1'b0;
		BUS_HIGH: return 1'b1;
		default:  return 1'($urandom_range(0, 1));
		endcase
	endfunction

	task automatic check_field(input string name, input int want, input int got);
		if (want != got) begin
			$display("%0t: %s expected %0h, got %0h", $time, name, want, got);
			mismatches++;
		end
	endtask

	// Queues a command, then just enough ticks to see it through and trail more. Commands
	// scattered among those ticks arrive while busy and must be ignored.
	task automatic issue(input logic [1:0] cmd, input logic [7:0] value, input int bus_mode,
			input int trail);
		int       span;
		in_item_t b;
		span = 0;
		case (cmd)
		KIND_RESET: begin
			span = int'(at_least_one(timing[REG_RESET_LOW]))
				+ int'(at_least_one(timing[REG_PRESENCE_WAIT])) + 1
				+ int'(timing[REG_RESET_TAIL]);
		end
		KIND_WRITE: begin
			for (int i = 0; i < 8; i++)
				span += value[i]
					? int'(at_least_one(timing[REG_WRITE_ONE_LOW]))
						+ int'(timing[REG_WRITE_ONE_TAIL])
					: int'(at_least_one(timing[REG_WRITE_ZERO_LOW]));
		end
		default: begin
			span = 8 * (int'(at_least_one(timing[REG_READ_LOW])) + 1
				+ int'(timing[REG_READ_TAIL]));
		end
		endcase
		b.kind       = cmd;
		b.write_data = value;
		b.bus_level  = bus_pick(bus_mode);
		pending_ticks.push_back(b);
		for (int i = 1; i < span + trail; i++) begin
			b.kind = (i < span && $urandom_range(0, 15) == 0) ? 2'($urandom_range(1, 3))
				: KIND_NONE;
			b.write_data = 8'($urandom);
			b.bus_level  = bus_pick(i < span ? bus_mode : BUS_RANDOM);
			pending_ticks.push_back(b);
		end
		ticks_queued += span + trail;
	endtask

	// Waits until every tick is sent, every result is in and the master is idle.
	task automatic settle();
		in_item_t idle_tick;
		idle_tick = '0;
		do begin
			while (pending_ticks.size() != 0 || in_valid || due_outputs.size() != 0) begin
				@(posedge clk);
				#1;
			end
			if (seq_phase != PH_IDLE)
				pending_ticks.push_back(idle_tick);
		end while (seq_phase != PH_IDLE);
		// allowance for the input register and the result buffer
		repeat (4) @(posedge clk);
	endtask

	task automatic load_timing(input int rl, input int pw, input int rt, input int ol,
			input int ot, input int zl, input int rdl, input int rdt);
		cfg_regs_t v;
		v[REG_RESET_LOW]      = REG_BITS'(rl);
		v[REG_PRESENCE_WAIT]  = REG_BITS'(pw);
		v[REG_RESET_TAIL]     = REG_BITS'(rt);
		v[REG_WRITE_ONE_LOW]  = REG_BITS'(ol);
		v[REG_WRITE_ONE_TAIL] = REG_BITS'(ot);
		v[REG_WRITE_ZERO_LOW] = REG_BITS'(zl);
		v[REG_READ_LOW]       = REG_BITS'(rdl);
		v[REG_READ_TAIL]      = REG_BITS'(rdt);
		for (int i = 0; i < NUM_REGS; i++) begin
			@(negedge clk);
			cfg_wr_en <= 1'b1;
			cfg_index <= 3'(i);
			cfg_data  <= v[3'(i)];
			timing[3'(i)] = v[3'(i)];
		end
		@(negedge clk);
		cfg_wr_en <= 1'b0;
		settings_run++;
	endtask

	// Sender: one beat at a time from the queue, with a drawn gap after each.
	always @(negedge clk) begin : sender
		if (arst_n && (!in_valid || in_taken)) begin
			if (send_gap > 0) begin
				in_valid <= 1'b0;
				send_gap--;
			end else if (pending_ticks.size() != 0) begin
				in_valid <= 1'b1;
				in_data  <= pending_ticks.pop_front();
				send_gap = pick_wait();
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// Receiver: after each result beat, stalls for a drawn number of cycles.
	always @(negedge clk) begin : receiver
		if (arst_n) begin
			if (out_taken)
				hold_left = pick_wait();
			out_stall <= (hold_left > 0);
			if (hold_left > 0)
				hold_left--;
		end
	end

	always @(posedge clk) begin : monitor
		out_item_t want;
		if (arst_n) begin
			cycle_count <= cycle_count + 1;
			in_taken    <= in_valid && !in_stall;
			out_taken   <= out_valid && !out_stall;
			if (in_valid && !in_stall) begin
				due_outputs.push_back(step_master(in_data));
				ticks_seen++;
			end
			if (out_valid && !out_stall) begin
				if (due_outputs.size() == 0) begin
					$display("%0t: result beat %0h with none expected", $time, out_data);
					mismatches++;
				end else begin
					want = due_outputs.pop_front();
					check_field("drive_low", want.drive_low, out_data.drive_low);
					check_field("busy_res", want.busy_res, out_data.busy_res);
					check_field("done_res", want.done_res, out_data.done_res);
					check_field("presence", want.presence, out_data.presence);
					check_field("read_data", want.read_data, out_data.read_data);
				end
			end
		end
	end

	initial begin : watchdog
		wait (cycle_count >= CYCLE_LIMIT);
		$display("timed out after %0d cycles", cycle_count);
		$display("end of test: mismatches");
		$finish;
	end

	initial begin : stimulus
		int          phase_start;
		int          pick;
		logic [1:0]  cmd;
		logic [7:0]  value;
		arst_n    = 1'b0;
		in_valid  = 1'b0;
		in_data   = '0;
		out_stall = 1'b0;
		cfg_wr_en = 1'b0;
		cfg_index = '0;
		cfg_data  = '0;
		timing[REG_RESET_LOW]      = RESET_LOW_DEF;
		timing[REG_PRESENCE_WAIT]  = PRESENCE_WAIT_DEF;
		timing[REG_RESET_TAIL]     = RESET_TAIL_DEF;
		timing[REG_WRITE_ONE_LOW]  = WRITE_ONE_LOW_DEF;
		timing[REG_WRITE_ONE_TAIL] = WRITE_ONE_TAIL_DEF;
		timing[REG_WRITE_ZERO_LOW] = WRITE_ZERO_LOW_DEF;
		timing[REG_READ_LOW]       = READ_LOW_DEF;
		timing[REG_READ_TAIL]      = READ_TAIL_DEF;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Timing as it comes out of reset: one write of a mixed byte, which uses both the
		// one and the zero bit slots, then a pause until everything has drained.
		settings_run++;
		issue(KIND_WRITE, 8'hA5, BUS_RANDOM, 1);
		settle();

		// Shortest lengths with every tail at zero.
		load_timing(1, 1, 0, 1, 0, 1, 1, 0);
		issue(KIND_RESET, 8'h00, BUS_HIGH, 1);
		issue(KIND_RESET, 8'h00, BUS_LOW, 0);
		issue(KIND_WRITE, 8'h00, BUS_RANDOM, 0);
		issue(KIND_WRITE, 8'hFF, BUS_RANDOM, 2);
		issue(KIND_READ, 8'h00, BUS_LOW, 0);
		issue(KIND_READ, 8'h00, BUS_HIGH, 1);
		issue(KIND_READ, 8'h00, BUS_RANDOM, 0);
		settle();

		// Random short timings with well-formed command streams.
		repeat (4) begin
			load_timing($urandom_range(1, 6), $urandom_range(1, 4), $urandom_range(0, 4),
				$urandom_range(1, 3), $urandom_range(0, 3), $urandom_range(1, 4),
				$urandom_range(1, 3), $urandom_range(0, 3));
			phase_start = ticks_queued;
			while (ticks_queued - phase_start < 25) begin
				pick  = $urandom_range(0, 9);
				cmd   = 2'($urandom_range(1, 3));
				value = (pick == 0) ? 8'h00 : (pick == 1) ? 8'hFF : 8'($urandom);
				issue(cmd, value, (pick < 8) ? BUS_RANDOM : pick - 8, $urandom_range(0, 2));
			end
			settle();
		end

		repeat (8) @(posedge clk);
		$display("ran %0d ticks and %0d commands over %0d timing settings",
			ticks_seen, commands_started, settings_run);
		$display("timings covered the reset values, the shortest with no tails and random short ones");
		if (mismatches == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule

>>> files.f
design/owb_pkg.sv
design/owb_engine.sv
design/one_wire_bus_master.sv
sim/testbench.sv
